// File: src/ndtag_pkg.sv
// Shared types and constants for the N-dimensional transpose address generator.
// Used by ndtag_cell, ndtag_setup and nd_transpose_address_generator_unit.
// No dependencies.
package ndtag_pkg;

    // Fixed register and field widths
    localparam int SIZE_W     = 16;
    localparam int ORDER_W    = 18;
    localparam int NUM_DIMS_W = 3;
    localparam int AXIS_W     = 3;
    localparam int AXES       = ORDER_W / AXIS_W;
    localparam int DIM_REGS   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Defaults for the top-level parameters
    localparam int MAX_DIMS_DEF   = 6;
    localparam int INDEX_BITS_DEF = 20;

    // Register reset values
    localparam logic [NUM_DIMS_W-1:0] NUM_DIMS_RST   = 3'd1;
    localparam logic [ORDER_W-1:0]    AXIS_ORDER_RST = 18'd181896;
    localparam logic [SIZE_W-1:0]     DIM_SIZE_RST   = 16'd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ORDER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0 = 3'd2;

    // Top-level sequencer
    typedef enum logic [2:0] {
        ST_RUN,
        ST_PROD,
        ST_CHECK,
        ST_LOAD,
        ST_EMIT
    } ndtag_state_t;

    // Sequencer to setup unit
    typedef struct packed {
        logic prod_init;
        logic prod_step;
        logic load_init;
        logic load_step;
    } setup_ctrl_t;

    // Setup unit to sequencer
    typedef struct packed {
        logic prod_last;
        logic load_done;
    } setup_stat_t;

endpackage

// File: src/ndtag_cell.sv
// One odometer digit of the transpose address generator: digit counter,
// wrap size and source-position step, with a shift path for loading.
// Depends on ndtag_pkg.
module ndtag_cell
    import ndtag_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift_en,
    input  logic [SIZE_W-1:0]     psize_in,
    input  logic [INDEX_BITS-1:0] delta_in,
    output logic [SIZE_W-1:0]     psize_out,
    output logic [INDEX_BITS-1:0] delta_out,
    input  logic                  adv_en,
    input  logic                  carry_in,
    input  logic                  carry_allow,
    output logic                  carry_out,
    output logic                  term
);

    logic [SIZE_W-1:0]     dc_reg;
    logic [SIZE_W-1:0]     dc_next;
    logic [SIZE_W-1:0]     dc_inc;
    logic [SIZE_W-1:0]     psize_reg;
    logic [INDEX_BITS-1:0] delta_reg;

    // Increment and wrap detect
    always_comb
    begin
        dc_inc    = dc_reg + SIZE_W'(1);
        carry_out = carry_in && carry_allow && (dc_inc == psize_reg);
        dc_next   = carry_out ? '0 : dc_inc;
        term      = carry_in && !carry_out;
    end

    // Digit state: shifted in during setup, stepped on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg    <= '0;
            psize_reg <= '0;
            delta_reg <= '0;
        end
        else if (shift_en)
        begin
            dc_reg    <= '0;
            psize_reg <= psize_in;
            delta_reg <= delta_in;
        end
        else if (adv_en && carry_in)
        begin
            dc_reg <= dc_next;
        end
    end

    assign psize_out = psize_reg;
    assign delta_out = delta_reg;

endmodule

// File: src/ndtag_setup.sv
// Setup unit: suffix products of the dimension sizes (one multiply a cycle)
// into a small memory, then per-digit size and cumulative step fed to the cells.
// Depends on ndtag_pkg.
module ndtag_setup
    import ndtag_pkg::*;
#(
    parameter int MAX_DIMS   = MAX_DIMS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  setup_ctrl_t                    ctrl,
    output setup_stat_t                    stat,
    input  logic [$clog2(MAX_DIMS+1)-1:0]  dims,
    input  logic [ORDER_W-1:0]             axis_order,
    input  logic [SIZE_W-1:0]              dim_size [DIM_REGS],
    output logic [INDEX_BITS:0]            total,
    output logic                           feed_shift,
    output logic [SIZE_W-1:0]              feed_psize,
    output logic [INDEX_BITS-1:0]          feed_delta
);

    localparam int AW = $clog2(MAX_DIMS + 1);
    localparam int CW = INDEX_BITS + 1;
    localparam int PW = CW + SIZE_W;
    localparam logic [PW-1:0] CAP_WIDE = PW'(1) << INDEX_BITS;
    localparam logic [CW-1:0] CAP_SAT  = CW'(CAP_WIDE) + CW'(1);

    // Size of an axis; unused or absent axes count as 1
    function automatic logic [SIZE_W-1:0] pick_size(
        input logic [AW-1:0]     idx,
        input logic [AW-1:0]     n,
        input logic [SIZE_W-1:0] sizes [DIM_REGS]
    );
        logic [SIZE_W-1:0] r;
        r = SIZE_W'(1);
        for (int k = 0; k < DIM_REGS; k++)
        begin
            if (int'(idx) == k && idx < n)
                r = sizes[k];
        end
        return r;
    endfunction

    logic [CW-1:0]         pmem [MAX_DIMS+1];
    logic [AW-1:0]         m_reg;
    logic [CW-1:0]         prod_reg;
    logic [CW-1:0]         prod_next;
    logic [PW-1:0]         prod_full;
    logic [AW-1:0]         s_reg;
    logic [INDEX_BITS-1:0] base_reg;
    logic [INDEX_BITS-1:0] base_next;
    logic                  rd_valid_reg;
    logic                  rd_zero_reg;
    logic                  rd_unit_reg;
    logic [SIZE_W-1:0]     rd_size_reg;
    logic [CW-1:0]         rd_ext_reg;
    logic [CW-1:0]         rd_str_reg;
    logic [AW-1:0]         out_axis;
    logic [AXIS_W-1:0]     src_axis;
    logic                  axis_ok;
    logic [AW-1:0]         rd_idx;
    logic                  issue;
    logic [INDEX_BITS-1:0] f_stride;
    logic [INDEX_BITS-1:0] f_extent;

    // Saturating suffix product
    always_comb
    begin
        prod_full = PW'(prod_reg) * PW'(pick_size(m_reg, dims, dim_size));
        prod_next = (prod_full > CAP_WIDE) ? CAP_SAT : prod_full[CW-1:0];
    end

    // Output axis for the cell being loaded, and its source axis
    always_comb
    begin
        out_axis = dims - AW'(1) - s_reg;
        src_axis = '0;
        for (int k = 0; k < AXES; k++)
        begin
            if (int'(out_axis) == k)
                src_axis = axis_order[AXIS_W*k +: AXIS_W];
        end
        axis_ok = int'(src_axis) < int'(dims);
        rd_idx  = axis_ok ? AW'(src_axis) : '0;
        issue   = ctrl.load_step && (s_reg < AW'(MAX_DIMS));
    end

    // Product sweep and memory write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg    <= '0;
            prod_reg <= '0;
        end
        else if (ctrl.prod_init)
        begin
            m_reg    <= dims;
            prod_reg <= CW'(1);
        end
        else if (ctrl.prod_step)
        begin
            m_reg    <= m_reg - AW'(1);
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_step)
            pmem[m_reg] <= prod_next;
    end

    // Registered reads: extent at the axis, stride one axis further in
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_ext_reg  <= pmem[rd_idx];
            rd_str_reg  <= pmem[rd_idx + AW'(1)];
            rd_zero_reg <= !(s_reg < dims);
            rd_unit_reg <= !axis_ok;
            rd_size_reg <= pick_size(rd_idx, dims, dim_size);
        end
    end

    // Load counter, read valid and cumulative step accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg        <= '0;
            base_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (ctrl.load_init)
            begin
                s_reg    <= '0;
                base_reg <= '0;
            end
            else
            begin
                if (issue)
                    s_reg <= s_reg + AW'(1);
                if (feed_shift)
                    base_reg <= base_next;
            end
        end
    end

    // Feed to the top cell
    always_comb
    begin
        if (rd_zero_reg)
        begin
            feed_psize = '0;
            f_stride   = '0;
            f_extent   = '0;
        end
        else if (rd_unit_reg)
        begin
            feed_psize = SIZE_W'(1);
            f_stride   = INDEX_BITS'(1);
            f_extent   = INDEX_BITS'(1);
        end
        else
        begin
            feed_psize = rd_size_reg;
            f_stride   = rd_str_reg[INDEX_BITS-1:0];
            f_extent   = rd_ext_reg[INDEX_BITS-1:0];
        end
        feed_delta = base_reg + f_stride;
        base_next  = feed_delta - f_extent;
    end

    assign feed_shift     = rd_valid_reg;
    assign total          = prod_reg;
    assign stat.prod_last = ctrl.prod_step && (m_reg == '0);
    assign stat.load_done = ctrl.load_step && (s_reg == AW'(MAX_DIMS));

endmodule

// File: src/nd_transpose_address_generator_unit.sv
// Top level of the N-dimensional transpose address generator: register file,
// sequencer, digit cell chain and output register.
// Depends on ndtag_pkg, ndtag_setup and ndtag_cell.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, start_req            | beat in
//   out     | out_valid, out_stall, src_index,         | beat out
//           | dst_index, last, overflow                |
//   cfg     | cfg_wr_en, cfg_index, cfg_data           | write only
//
// An advance beat: the carry ripples through the cell chain and one add forms
// the next source index, so addresses stream one per cycle unless out_stall
// holds them. A start beat runs setup: accept, product sweep (one multiply
// per step), check, cell load, element 0; overflow skips the load and a zero
// total emits nothing. Input stalls during setup and while an undelivered
// result blocks the output register. Reset: idle, with default registers.
module nd_transpose_address_generator_unit
    import ndtag_pkg::*;
#(
    parameter int MAX_DIMS   = MAX_DIMS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  start_req,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [INDEX_BITS-1:0] src_index,
    output logic [INDEX_BITS-1:0] dst_index,
    output logic                  last,
    output logic                  overflow
);

    localparam int AW = $clog2(MAX_DIMS + 1);
    localparam int CW = INDEX_BITS + 1;
    localparam logic [CW-1:0] CAPACITY = CW'(1) << INDEX_BITS;

    // Configuration registers
    logic [NUM_DIMS_W-1:0] num_dims_reg;
    logic [ORDER_W-1:0]    axis_order_reg;
    logic [SIZE_W-1:0]     dim_size_reg [DIM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg   <= NUM_DIMS_RST;
            axis_order_reg <= AXIS_ORDER_RST;
            for (int k = 0; k < DIM_REGS; k++)
                dim_size_reg[k] <= DIM_SIZE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_NUM_DIMS:   num_dims_reg   <= cfg_data[NUM_DIMS_W-1:0];
                CFG_AXIS_ORDER: axis_order_reg <= cfg_data[ORDER_W-1:0];
                default:
                begin
                    for (int k = 0; k < DIM_REGS; k++)
                    begin
                        if (cfg_index == CFG_DIM_SIZE_0 + CFG_IDX_W'(k))
                            dim_size_reg[k] <= cfg_data[SIZE_W-1:0];
                    end
                end
            endcase
        end
    end

    // Dimensions in use, clamped to 1..MAX_DIMS
    logic [NUM_DIMS_W:0] nd_ext;
    logic [AW-1:0]       dims;

    always_comb
    begin
        nd_ext = {1'b0, num_dims_reg};
        if (nd_ext == '0)
            dims = AW'(1);
        else if (int'(nd_ext) > MAX_DIMS)
            dims = AW'(MAX_DIMS);
        else
            dims = AW'(nd_ext);
    end

    // Setup unit
    setup_ctrl_t           ctrl;
    setup_stat_t           stat;
    logic [CW-1:0]         total;
    logic                  feed_shift;
    logic [SIZE_W-1:0]     feed_psize;
    logic [INDEX_BITS-1:0] feed_delta;

    ndtag_setup #(
        .MAX_DIMS   (MAX_DIMS),
        .INDEX_BITS (INDEX_BITS)
    ) u_setup (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .dims       (dims),
        .axis_order (axis_order_reg),
        .dim_size   (dim_size_reg),
        .total      (total),
        .feed_shift (feed_shift),
        .feed_psize (feed_psize),
        .feed_delta (feed_delta)
    );

    // Digit cell chain: loads shift downward, carries ripple upward
    logic [SIZE_W-1:0]     psize_w [MAX_DIMS+1];
    logic [INDEX_BITS-1:0] delta_w [MAX_DIMS+1];
    logic [MAX_DIMS-1:0]   carry_w;
    logic [MAX_DIMS-1:0]   term_w;
    logic                  adv_fire;

    assign psize_w[MAX_DIMS] = feed_psize;
    assign delta_w[MAX_DIMS] = feed_delta;

    for (genvar k = 0; k < MAX_DIMS; k++)
    begin : g_cell
        logic cin;
        if (k == 0)
        begin : g_first
            assign cin = 1'b1;
        end
        else
        begin : g_rest
            assign cin = carry_w[k-1];
        end

        ndtag_cell #(
            .INDEX_BITS (INDEX_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift_en    (feed_shift),
            .psize_in    (psize_w[k+1]),
            .delta_in    (delta_w[k+1]),
            .psize_out   (psize_w[k]),
            .delta_out   (delta_w[k]),
            .adv_en      (adv_fire),
            .carry_in    (cin),
            .carry_allow (dims > AW'(k + 1)),
            .carry_out   (carry_w[k]),
            .term        (term_w[k])
        );
    end

    // Step of the highest digit reached by the carry
    logic [INDEX_BITS-1:0] sel_delta;

    always_comb
    begin
        sel_delta = '0;
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            if (term_w[k])
                sel_delta = sel_delta | delta_w[k];
        end
    end

    // Sequencer
    ndtag_state_t          state_reg;
    ndtag_state_t          state_next;
    logic                  out_valid_reg;
    logic                  slot_free;
    logic                  emit;
    logic                  start_fire;
    logic                  active_reg;
    logic [INDEX_BITS-1:0] src_pos_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [INDEX_BITS-1:0] src_next;
    logic                  adv_last;

    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RUN;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_stall   = 1'b1;
        adv_fire   = 1'b0;
        start_fire = 1'b0;
        emit       = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                in_stall = !slot_free;
                if (in_valid && slot_free)
                begin
                    if (start_req)
                    begin
                        start_fire     = 1'b1;
                        ctrl.prod_init = 1'b1;
                        state_next     = ST_PROD;
                    end
                    else if (active_reg)
                    begin
                        adv_fire = 1'b1;
                    end
                end
            end
            ST_PROD:
            begin
                ctrl.prod_step = 1'b1;
                if (stat.prod_last)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (total == '0)
                    state_next = ST_RUN;
                else if (total > CAPACITY)
                    state_next = ST_EMIT;
                else
                begin
                    ctrl.load_init = 1'b1;
                    state_next     = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ctrl.load_step = 1'b1;
                if (stat.load_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Advance datapath
    always_comb
    begin
        count_next = count_reg + CW'(1);
        src_next   = src_pos_reg + sel_delta;
        adv_last   = ({1'b0, count_next} + (CW+1)'(1)) >= {1'b0, total};
    end

    // Walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            src_pos_reg <= '0;
            count_reg   <= '0;
        end
        else if (start_fire)
        begin
            active_reg <= 1'b0;
        end
        else if (emit)
        begin
            active_reg  <= (total > CW'(1)) && !(total > CAPACITY);
            src_pos_reg <= '0;
            count_reg   <= '0;
        end
        else if (adv_fire)
        begin
            src_pos_reg <= src_next;
            count_reg   <= count_next;
            if (adv_last)
                active_reg <= 1'b0;
        end
    end

    // Output register
    logic [INDEX_BITS-1:0] src_index_reg;
    logic [INDEX_BITS-1:0] dst_index_reg;
    logic                  last_reg;
    logic                  overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit || adv_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            src_index_reg <= '0;
            dst_index_reg <= '0;
            overflow_reg  <= total > CAPACITY;
            last_reg      <= (total == CW'(1));
        end
        else if (adv_fire)
        begin
            src_index_reg <= src_next;
            dst_index_reg <= count_next[INDEX_BITS-1:0];
            overflow_reg  <= 1'b0;
            last_reg      <= adv_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign src_index = src_index_reg;
    assign dst_index = dst_index_reg;
    assign last      = last_reg;
    assign overflow  = overflow_reg;

endmodule
